/* src/cbc_pkg.sv */
package cbc_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 17;
  localparam logic [30:0] RadiusReset = 31'd32768;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vz;
    logic [30:0]        r;
    logic signed [31:0] dx;
    logic signed [31:0] dz;
    logic               near_hit;
    logic signed [31:0] res_px;
    logic signed [31:0] res_pz;
    logic signed [31:0] res_vx;
    logic signed [31:0] res_vz;
    logic               res_hit;
  } carry_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [32:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] d;
    logic [31:0] rem_x;
    logic [31:0] rem_z;
    logic        nb_x;
    logic        nb_z;
    logic [16:0] q_x;
    logic [16:0] q_z;
  } div_t;

  typedef struct packed {
    logic en;
    logic vld;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

/* src/cbc_in_if.sv */
interface cbc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_z;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_z;

  modport source (output valid, pos_x, pos_z, vel_x, vel_z, box_min_x, box_min_z,
                  box_max_x, box_max_z, input ready);
  modport sink (input valid, pos_x, pos_z, vel_x, vel_z, box_min_x, box_min_z,
                box_max_x, box_max_z, output ready);
endinterface

/* src/cbc_out_if.sv */
interface cbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_z;
  logic               hit;

  modport source (output valid, new_pos_x, new_pos_z, new_vel_x, new_vel_z, hit,
                  input ready);
  modport sink (input valid, new_pos_x, new_pos_z, new_vel_x, new_vel_z, hit,
                output ready);
endinterface

/* src/cbc_sqrt_cell.sv */
module cbc_sqrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbc_pkg::cell_ctl_t ctl_i,
  input  cbc_pkg::carry_t   carry_i,
  input  cbc_pkg::sqrt_t    sq_i,
  output logic              vld_o,
  output cbc_pkg::carry_t   carry_o,
  output cbc_pkg::sqrt_t    sq_o
);

  logic [34:0]     wide;
  logic [34:0]     trial;
  logic            ge;
  cbc_pkg::sqrt_t  sq_d;
  logic            vld_q;
  cbc_pkg::carry_t carry_q;
  cbc_pkg::sqrt_t  sq_q;

  always_comb begin
    wide     = {sq_i.rem, sq_i.rad[63:62]};
    trial    = {1'b0, sq_i.root, 2'b01};
    ge       = (wide >= trial);
    sq_d.rad = {sq_i.rad[61:0], 2'b00};
    sq_d.rem = ge ? 33'(wide - trial) : wide[32:0];
    sq_d.root = {sq_i.root[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      carry_q <= carry_i;
      sq_q    <= sq_d;
    end
  end

  assign vld_o   = vld_q;
  assign carry_o = carry_q;
  assign sq_o    = sq_q;

endmodule

/* src/cbc_div_cell.sv */
module cbc_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbc_pkg::cell_ctl_t ctl_i,
  input  cbc_pkg::carry_t   carry_i,
  input  cbc_pkg::div_t     dv_i,
  output logic              vld_o,
  output cbc_pkg::carry_t   carry_o,
  output cbc_pkg::div_t     dv_o
);

  logic [32:0]     wx;
  logic [32:0]     wz;
  logic [32:0]     dd;
  logic            gx;
  logic            gz;
  cbc_pkg::div_t   dv_d;
  logic            vld_q;
  cbc_pkg::carry_t carry_q;
  cbc_pkg::div_t   dv_q;

  always_comb begin
    dd         = {1'b0, dv_i.d};
    wx         = {dv_i.rem_x, dv_i.nb_x};
    wz         = {dv_i.rem_z, dv_i.nb_z};
    gx         = (wx >= dd);
    gz         = (wz >= dd);
    dv_d.d     = dv_i.d;
    dv_d.rem_x = gx ? 32'(wx - dd) : wx[31:0];
    dv_d.rem_z = gz ? 32'(wz - dd) : wz[31:0];
    dv_d.nb_x  = 1'b0;
    dv_d.nb_z  = 1'b0;
    dv_d.q_x   = {dv_i.q_x[15:0], gx};
    dv_d.q_z   = {dv_i.q_z[15:0], gz};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      carry_q <= carry_i;
      dv_q    <= dv_d;
    end
  end

  assign vld_o   = vld_q;
  assign carry_o = carry_q;
  assign dv_o    = dv_q;

endmodule

/* src/circle_box_collision_resolve.sv */
// Channel   Direction  Payload
// req_i     in         pos_x, pos_z, vel_x, vel_z, box_min_x/z, box_max_x/z
// rsp_o     out        new_pos_x, new_pos_z, new_vel_x, new_vel_z, hit
// cfg       in         cfg_we_i, cfg_wdata_i (circle radius, unsigned Q15.16)
//
// One item is accepted per cycle while no result waits at the output.
// The pipeline has 57 register stages, 32 square root cells and 17 divider cells among them.
// Reset empties the pipeline and sets the radius to 0.5.
// When a result waits at the output, the whole pipeline holds and req_i.ready drops.
module circle_box_collision_resolve (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  cbc_in_if.sink      req_i,
  cbc_out_if.source   rsp_o
);

  logic        adv;
  logic [30:0] radius_q;

  // Stage 1
  logic signed [31:0] mxx, mxz, qx, qz;
  logic               s1_v_q;
  cbc_pkg::carry_t    s1_c_q;
  logic signed [31:0] s1_qx_q, s1_qz_q;
  logic signed [32:0] s1_l_q, s1_rt_q, s1_dn_q, s1_up_q;

  // Stage 2
  logic               s2_v_q;
  cbc_pkg::carry_t    s2_c_q;
  logic signed [32:0] s2_dx_q, s2_dz_q, s2_minx_q, s2_minz_q;
  logic               s2_posx_q, s2_posz_q;

  // Stage 3
  logic               outside, near;
  logic [32:0]        adx, adz;
  logic signed [34:0] rs, push, np;
  cbc_pkg::carry_t    c3;
  logic               s3_v_q;
  cbc_pkg::carry_t    s3_c_q;
  logic [61:0]        s3_sqx_q, s3_sqz_q, s3_rr_q;

  // Stage 4
  logic [62:0]        d2;
  cbc_pkg::carry_t    c4;
  logic               s4_v_q;
  cbc_pkg::carry_t    s4_c_q;
  cbc_pkg::sqrt_t     s4_sq_q;

  logic               sq_v [cbc_pkg::SqrtSteps+1];
  cbc_pkg::carry_t    sq_c [cbc_pkg::SqrtSteps+1];
  cbc_pkg::sqrt_t     sq_d [cbc_pkg::SqrtSteps+1];
  logic               dv_v [cbc_pkg::DivSteps+1];
  cbc_pkg::carry_t    dv_c [cbc_pkg::DivSteps+1];
  cbc_pkg::div_t      dv_d [cbc_pkg::DivSteps+1];

  logic [31:0]        ax, az;

  // Multiply stages
  logic signed [17:0] nx, nz;
  logic signed [32:0] pushd;
  logic               m1_v_q;
  cbc_pkg::carry_t    m1_c_q;
  logic signed [17:0] m1_nx_q, m1_nz_q;
  logic signed [50:0] m1_prx_q, m1_prz_q;
  logic signed [49:0] m1_pvx_q, m1_pvz_q;

  logic signed [35:0] npx, npz;
  logic signed [50:0] sum;
  logic               m2_v_q;
  cbc_pkg::carry_t    m2_c_q;
  logic signed [17:0] m2_nx_q, m2_nz_q;
  logic signed [31:0] m2_npx_q, m2_npz_q;
  logic signed [34:0] m2_vn_q;
  logic               m2_neg_q;

  logic               m3_v_q;
  cbc_pkg::carry_t    m3_c_q;
  logic signed [31:0] m3_npx_q, m3_npz_q;
  logic signed [52:0] m3_mvx_q, m3_mvz_q;
  logic               m3_neg_q;

  logic signed [53:0] nvx, nvz;
  logic               o_v_q;
  logic signed [31:0] o_px_q, o_pz_q, o_vx_q, o_vz_q;
  logic               o_hit_q;

  assign adv         = !o_v_q || rsp_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= cbc_pkg::RadiusReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    mxx = (req_i.pos_x > req_i.box_min_x) ? req_i.pos_x : req_i.box_min_x;
    qx  = (mxx < req_i.box_max_x) ? mxx : req_i.box_max_x;
    mxz = (req_i.pos_z > req_i.box_min_z) ? req_i.pos_z : req_i.box_min_z;
    qz  = (mxz < req_i.box_max_z) ? mxz : req_i.box_max_z;
  end

  always_comb begin
    outside = (s2_dx_q != 33'sd0) || (s2_dz_q != 33'sd0);
    adx     = (s2_dx_q < 0) ? 33'(-s2_dx_q) : 33'(s2_dx_q);
    adz     = (s2_dz_q < 0) ? 33'(-s2_dz_q) : 33'(s2_dz_q);
    near    = (adx < {2'b00, s2_c_q.r}) && (adz < {2'b00, s2_c_q.r});
    rs      = $signed({4'b0000, s2_c_q.r});
    c3      = s2_c_q;
    c3.dx   = s2_dx_q[31:0];
    c3.dz   = s2_dz_q[31:0];
    c3.near_hit = outside && near;
    c3.res_px = s2_c_q.px;
    c3.res_pz = s2_c_q.pz;
    c3.res_vx = s2_c_q.vx;
    c3.res_vz = s2_c_q.vz;
    c3.res_hit = !outside;
    push    = '0;
    np      = '0;
    if (!outside) begin
      if (s2_minx_q < s2_minz_q) begin
        push = 35'(s2_minx_q) + rs;
        np   = s2_posx_q ? 35'(s2_c_q.px) + push : 35'(s2_c_q.px) - push;
        c3.res_px = cbc_pkg::sat32(64'(np));
        if (s2_posx_q ? (s2_c_q.vx < 0) : (s2_c_q.vx > 0)) begin
          c3.res_vx = '0;
        end
      end else begin
        push = 35'(s2_minz_q) + rs;
        np   = s2_posz_q ? 35'(s2_c_q.pz) + push : 35'(s2_c_q.pz) - push;
        c3.res_pz = cbc_pkg::sat32(64'(np));
        if (s2_posz_q ? (s2_c_q.vz < 0) : (s2_c_q.vz > 0)) begin
          c3.res_vz = '0;
        end
      end
    end
  end

  always_comb begin
    d2 = 63'(s3_sqx_q) + 63'(s3_sqz_q);
    c4 = s3_c_q;
    c4.near_hit = s3_c_q.near_hit && (d2 < 63'(s3_rr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (adv) begin
      s1_v_q <= req_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      m1_v_q <= dv_v[cbc_pkg::DivSteps];
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      o_v_q  <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_c_q        <= '{px: req_i.pos_x, pz: req_i.pos_z, vx: req_i.vel_x,
                         vz: req_i.vel_z, r: radius_q, default: '0};
      s1_qx_q       <= qx;
      s1_qz_q       <= qz;
      s1_l_q        <= 33'(req_i.pos_x) - 33'(req_i.box_min_x);
      s1_rt_q       <= 33'(req_i.box_max_x) - 33'(req_i.pos_x);
      s1_dn_q       <= 33'(req_i.pos_z) - 33'(req_i.box_min_z);
      s1_up_q       <= 33'(req_i.box_max_z) - 33'(req_i.pos_z);

      s2_c_q        <= s1_c_q;
      s2_dx_q       <= 33'(s1_c_q.px) - 33'(s1_qx_q);
      s2_dz_q       <= 33'(s1_c_q.pz) - 33'(s1_qz_q);
      s2_minx_q     <= (s1_l_q < s1_rt_q) ? s1_l_q : s1_rt_q;
      s2_minz_q     <= (s1_dn_q < s1_up_q) ? s1_dn_q : s1_up_q;
      s2_posx_q     <= (s1_l_q < s1_rt_q);
      s2_posz_q     <= (s1_dn_q < s1_up_q);

      s3_c_q        <= c3;
      s3_sqx_q      <= 62'(adx[30:0]) * 62'(adx[30:0]);
      s3_sqz_q      <= 62'(adz[30:0]) * 62'(adz[30:0]);
      s3_rr_q       <= 62'(s2_c_q.r) * 62'(s2_c_q.r);

      s4_c_q        <= c4;
      s4_sq_q.rad   <= 64'(d2);
      s4_sq_q.rem   <= '0;
      s4_sq_q.root  <= '0;

      m1_c_q        <= dv_c[cbc_pkg::DivSteps];
      m1_nx_q       <= nx;
      m1_nz_q       <= nz;
      m1_prx_q      <= 51'(nx) * 51'(pushd);
      m1_prz_q      <= 51'(nz) * 51'(pushd);
      m1_pvx_q      <= 50'(dv_c[cbc_pkg::DivSteps].vx) * 50'(nx);
      m1_pvz_q      <= 50'(dv_c[cbc_pkg::DivSteps].vz) * 50'(nz);

      m2_c_q        <= m1_c_q;
      m2_nx_q       <= m1_nx_q;
      m2_nz_q       <= m1_nz_q;
      m2_npx_q      <= cbc_pkg::sat32(64'(npx));
      m2_npz_q      <= cbc_pkg::sat32(64'(npz));
      m2_vn_q       <= 35'(sum >>> 16);
      m2_neg_q      <= (sum < 0);

      m3_c_q        <= m2_c_q;
      m3_npx_q      <= m2_npx_q;
      m3_npz_q      <= m2_npz_q;
      m3_mvx_q      <= 53'(m2_vn_q) * 53'(m2_nx_q);
      m3_mvz_q      <= 53'(m2_vn_q) * 53'(m2_nz_q);
      m3_neg_q      <= m2_neg_q;

      if (m3_c_q.near_hit) begin
        o_px_q  <= m3_npx_q;
        o_pz_q  <= m3_npz_q;
        o_vx_q  <= cbc_pkg::sat32(64'(nvx));
        o_vz_q  <= cbc_pkg::sat32(64'(nvz));
        o_hit_q <= 1'b1;
      end else begin
        o_px_q  <= m3_c_q.res_px;
        o_pz_q  <= m3_c_q.res_pz;
        o_vx_q  <= m3_c_q.res_vx;
        o_vz_q  <= m3_c_q.res_vz;
        o_hit_q <= m3_c_q.res_hit;
      end
    end
  end

  assign sq_v[0] = s4_v_q;
  assign sq_c[0] = s4_c_q;
  assign sq_d[0] = s4_sq_q;

  for (genvar i = 0; i < cbc_pkg::SqrtSteps; i++) begin : g_sqrt
    cbc_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   ('{en: adv, vld: sq_v[i]}),
      .carry_i (sq_c[i]),
      .sq_i    (sq_d[i]),
      .vld_o   (sq_v[i+1]),
      .carry_o (sq_c[i+1]),
      .sq_o    (sq_d[i+1])
    );
  end

  always_comb begin
    ax = (sq_c[cbc_pkg::SqrtSteps].dx < 0) ? 32'(-sq_c[cbc_pkg::SqrtSteps].dx)
                                           : 32'(sq_c[cbc_pkg::SqrtSteps].dx);
    az = (sq_c[cbc_pkg::SqrtSteps].dz < 0) ? 32'(-sq_c[cbc_pkg::SqrtSteps].dz)
                                           : 32'(sq_c[cbc_pkg::SqrtSteps].dz);
    dv_d[0].d     = (sq_d[cbc_pkg::SqrtSteps].root == 32'd0) ? 32'd1
                                                             : sq_d[cbc_pkg::SqrtSteps].root;
    dv_d[0].rem_x = {1'b0, ax[31:1]};
    dv_d[0].rem_z = {1'b0, az[31:1]};
    dv_d[0].nb_x  = ax[0];
    dv_d[0].nb_z  = az[0];
    dv_d[0].q_x   = '0;
    dv_d[0].q_z   = '0;
  end

  assign dv_v[0] = sq_v[cbc_pkg::SqrtSteps];
  assign dv_c[0] = sq_c[cbc_pkg::SqrtSteps];

  for (genvar j = 0; j < cbc_pkg::DivSteps; j++) begin : g_div
    cbc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   ('{en: adv, vld: dv_v[j]}),
      .carry_i (dv_c[j]),
      .dv_i    (dv_d[j]),
      .vld_o   (dv_v[j+1]),
      .carry_o (dv_c[j+1]),
      .dv_o    (dv_d[j+1])
    );
  end

  always_comb begin
    nx = (dv_c[cbc_pkg::DivSteps].dx < 0) ? -$signed({1'b0, dv_d[cbc_pkg::DivSteps].q_x})
                                          : $signed({1'b0, dv_d[cbc_pkg::DivSteps].q_x});
    nz = (dv_c[cbc_pkg::DivSteps].dz < 0) ? -$signed({1'b0, dv_d[cbc_pkg::DivSteps].q_z})
                                          : $signed({1'b0, dv_d[cbc_pkg::DivSteps].q_z});
    pushd = $signed({2'b00, dv_c[cbc_pkg::DivSteps].r})
          - $signed({1'b0, dv_d[cbc_pkg::DivSteps].d});
  end

  always_comb begin
    npx = 36'(m1_c_q.px) + 36'(m1_prx_q >>> 16);
    npz = 36'(m1_c_q.pz) + 36'(m1_prz_q >>> 16);
    sum = 51'(m1_pvx_q) + 51'(m1_pvz_q);
  end

  always_comb begin
    nvx = 54'(m3_c_q.vx);
    nvz = 54'(m3_c_q.vz);
    if (m3_neg_q) begin
      nvx = 54'(m3_c_q.vx) - 54'(m3_mvx_q >>> 16);
      nvz = 54'(m3_c_q.vz) - 54'(m3_mvz_q >>> 16);
    end
  end

  assign rsp_o.valid     = o_v_q;
  assign rsp_o.new_pos_x = o_px_q;
  assign rsp_o.new_pos_z = o_pz_q;
  assign rsp_o.new_vel_x = o_vx_q;
  assign rsp_o.new_vel_z = o_vz_q;
  assign rsp_o.hit       = o_hit_q;

endmodule

/* src/cbc_checker.sv */
module cbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_pos_x_i,
  input logic [31:0] rsp_vel_x_i,
  input logic        rsp_hit_i
);

  a_rsp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_pos_x_i)
      && $stable(rsp_vel_x_i) && $stable(rsp_hit_i))
    else $error("Stalled result item changed.");

  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i == (!rsp_valid_i || rsp_ready_i))
    else $error("Input ready does not follow output backpressure.");

  a_reset_empty : assert property (@(posedge clk_i)
    !rst_ni |-> !rsp_valid_i)
    else $error("Result item shown during reset.");

  a_no_early : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !rsp_valid_i)
    else $error("Result item right after reset.");

  a_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({req_valid_i, req_ready_i, rsp_valid_i, rsp_ready_i}))
    else $error("Handshake signal is unknown.");

endmodule

bind circle_box_collision_resolve cbc_checker u_cbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_pos_x_i (rsp_o.new_pos_x),
  .rsp_vel_x_i (rsp_o.new_vel_x),
  .rsp_hit_i   (rsp_o.hit)
);
